@@ rtl/aotq_pkg.sv @@
`default_nettype none

package aotq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 16;
	localparam int STAMP_W     = 32;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ_ANY = 2'd1,
		CMD_DEQ_C0 = 2'd2,
		CMD_DEQ_C1 = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/age_ordered_two_class_queue.sv @@
// A command taken at an accept edge moves the block to the execute state; the result word is
// registered at the end of that execute cycle, with done high in the cycle after it.
// A new command is not taken while busy is high; busy is high for the cycle in which the heads
// read from the two entry RAMs are used, and the next command may start in the result cycle.
// Reset (arst_n low, asynchronous): both queues empty, stamp counter zero, no result pending;
// RAM contents are not cleared. The receiver cannot stall: done lasts exactly one cycle.
`default_nettype none

module age_ordered_two_class_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic        item_class,
	input  wire logic [15:0] item_tag,
	output logic             done,
	output logic             found,
	output logic             out_class,
	output logic [15:0]      out_tag,
	output logic [31:0]      out_stamp,
	output logic [1:0]       status
);

	localparam int Depth = aotq_pkg::QUEUE_DEPTH;
	localparam int TagW  = aotq_pkg::TAG_BITS;
	localparam int PtrW  = aotq_pkg::PTR_W;
	localparam int CntW  = aotq_pkg::CNT_W;
	localparam int StW   = aotq_pkg::STAMP_W;

	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	// entry RAMs, one per class
	aotq_pkg::entry_t mem0 [Depth];
	aotq_pkg::entry_t mem1 [Depth];

	aotq_pkg::state_t state_q;

	// queue pointers and occupancy
	logic [PtrW-1:0] head0_q, tail0_q, head1_q, tail1_q;
	logic [CntW-1:0] cnt0_q, cnt1_q;
	logic [StW-1:0]  stamp_q;

	// command captured at accept
	aotq_pkg::cmd_t  cmd_q;
	logic            cls_q;
	logic [TagW-1:0] tag_q;

	// head words, registered RAM read
	aotq_pkg::entry_t rd0_s1, rd1_s1;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q == aotq_pkg::S_EXEC);

	// next-state logic for the execute cycle
	logic             wr0, wr1, pop0, pop1, stamp_inc;
	aotq_pkg::entry_t wr_word;
	logic             res_found, res_class;
	logic [TagW-1:0]  res_tag;
	logic [StW-1:0]   res_stamp;
	aotq_pkg::status_t res_status;
	logic [StW-1:0]   age_diff;
	logic             older0;

	// class 0 head older when the modular difference is negative; ties go to class 1
	assign age_diff = rd0_s1.stamp - rd1_s1.stamp;
	assign older0   = age_diff[StW-1];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
	endfunction

	// the captured command only acts in the execute cycle
	always_comb begin
		wr0        = 1'b0;
		wr1        = 1'b0;
		pop0       = 1'b0;
		pop1       = 1'b0;
		stamp_inc  = 1'b0;
		wr_word    = '{tag: tag_q, stamp: stamp_q};
		res_found  = 1'b0;
		res_class  = 1'b0;
		res_tag    = '0;
		res_stamp  = '0;
		res_status = aotq_pkg::ST_EMPTY;
		if (busy) begin
			unique case (cmd_q)
				aotq_pkg::CMD_ENQ: begin
					res_class = cls_q;
					res_tag   = tag_q;
					res_stamp = stamp_q;
					if ((cls_q ? cnt1_q : cnt0_q) == FullCnt) begin
						res_status = aotq_pkg::ST_FULL;
					end else begin
						res_status = aotq_pkg::ST_OK;
						wr0        = !cls_q;
						wr1        = cls_q;
						stamp_inc  = 1'b1;
					end
				end
				aotq_pkg::CMD_DEQ_C0: begin
					pop0 = (cnt0_q != '0);
				end
				aotq_pkg::CMD_DEQ_C1: begin
					pop1 = (cnt1_q != '0);
				end
				aotq_pkg::CMD_DEQ_ANY: begin
					if (cnt0_q != '0 && cnt1_q != '0) begin
						pop0 = older0;
						pop1 = !older0;
					end else begin
						pop0 = (cnt0_q != '0);
						pop1 = (cnt1_q != '0);
					end
				end
				default: ;
			endcase
		end
		if (pop0 || pop1) begin
			res_found  = 1'b1;
			res_class  = pop1;
			res_tag    = pop1 ? rd1_s1.tag : rd0_s1.tag;
			res_stamp  = pop1 ? rd1_s1.stamp : rd0_s1.stamp;
			res_status = aotq_pkg::ST_OK;
		end
	end

	// RAMs: read heads at accept, write tail in the execute cycle.
	// busy holds off the next read until the write has landed.
	always_ff @(posedge clk) begin
		if (wr0) begin
			mem0[tail0_q] <= wr_word;
		end
		if (wr1) begin
			mem1[tail1_q] <= wr_word;
		end
		if (accept) begin
			rd0_s1 <= mem0[head0_q];
			rd1_s1 <= mem1[head1_q];
		end
	end

	// command capture and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= aotq_pkg::cmd_t'(cmd);
			cls_q <= item_class;
			tag_q <= TagW'(item_tag);
		end
		if (busy) begin
			found     <= res_found;
			out_class <= res_class;
			out_tag   <= 16'(res_tag);
			out_stamp <= res_stamp;
			status    <= res_status;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aotq_pkg::S_IDLE;
			done    <= 1'b0;
			head0_q <= '0;
			tail0_q <= '0;
			head1_q <= '0;
			tail1_q <= '0;
			cnt0_q  <= '0;
			cnt1_q  <= '0;
			stamp_q <= '0;
		end else begin
			done <= busy;
			unique case (state_q)
				aotq_pkg::S_IDLE: begin
					if (start) begin
						state_q <= aotq_pkg::S_EXEC;
					end
				end
				aotq_pkg::S_EXEC: begin
					state_q <= aotq_pkg::S_IDLE;
				end
				default: state_q <= aotq_pkg::S_IDLE;
			endcase
			if (wr0) begin
				tail0_q <= ptr_inc(tail0_q);
				cnt0_q  <= cnt0_q + CntW'(1);
			end
			if (wr1) begin
				tail1_q <= ptr_inc(tail1_q);
				cnt1_q  <= cnt1_q + CntW'(1);
			end
			if (pop0) begin
				head0_q <= ptr_inc(head0_q);
				cnt0_q  <= cnt0_q - CntW'(1);
			end
			if (pop1) begin
				head1_q <= ptr_inc(head1_q);
				cnt1_q  <= cnt1_q - CntW'(1);
			end
			if (stamp_inc) begin
				stamp_q <= stamp_q + StW'(1);
			end
		end
	end

	// occupancy never exceeds the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt0_q <= FullCnt) && (cnt1_q <= FullCnt))
		else $error("queue occupancy beyond depth");

	// an execute cycle is always followed by a result word
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle without result");

	// execute never lasts more than one cycle
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for two cycles");

	// a successful enqueue advances the stamp by one
	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found && status == aotq_pkg::ST_OK) |-> (stamp_q == out_stamp + StW'(1)))
		else $error("stamp not advanced on enqueue");

	// a found entry always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == aotq_pkg::ST_OK))
		else $error("found entry with bad status");

endmodule

`default_nettype wire

@@ sim/age_ordered_two_class_queue_test.sv @@
`default_nettype none

module age_ordered_two_class_queue_test;

	// Watchdog limit: cycles in a row with neither a command taken nor a result word seen.
	// The limit is many times the longest sender gap from pick_gap plus the time the block
	// takes to answer, so it is far beyond the slowest correct stretch.
	localparam int STALL_LIMIT = 600;
	localparam int RANDOM_WORDS = 1250;
	localparam int SHOW_LIMIT = 10;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = aotq_pkg::CMD_ENQ;
	logic        item_class = 1'b0;
	logic [15:0] item_tag = '0;
	logic        busy;
	logic        done;
	logic        found;
	logic        out_class;
	logic [15:0] out_tag;
	logic [31:0] out_stamp;
	logic [1:0]  status;

	age_ordered_two_class_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.item_class(item_class),
		.item_tag  (item_tag),
		.done      (done),
		.found     (found),
		.out_class (out_class),
		.out_tag   (out_tag),
		.out_stamp (out_stamp),
		.status    (status)
	);

	// One expected result word.
	typedef struct packed {
		logic              found;
		logic              cls;
		logic [15:0]       tag;
		logic [31:0]       stamp;
		aotq_pkg::status_t status;
	} outcome_t;

	outcome_t pending_outcomes[$];

	// Shadow copy of both class queues and the arrival counter.
	aotq_pkg::entry_t           shelf [2][aotq_pkg::QUEUE_DEPTH];
	logic [aotq_pkg::PTR_W-1:0] rd_ptr [2];
	logic [aotq_pkg::PTR_W-1:0] wr_ptr [2];
	int                         fill [2];
	logic [31:0]                stamp_ctr;

	int mismatches = 0;
	int words_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int enq_ok = 0;
	int enq_dropped = 0;
	int deq_found = 0;
	int deq_empty = 0;
	int any_picks [2] = '{0, 0};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [aotq_pkg::PTR_W-1:0] ptr_step(
			input logic [aotq_pkg::PTR_W-1:0] p);
		return (p == aotq_pkg::PTR_W'(aotq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Works out the result word of one accepted command and updates the shadow state.
	task automatic predict_outcome(input aotq_pkg::cmd_t c, input logic cls,
			input logic [15:0] tag);
		outcome_t o;
		logic     pick;
		logic     any_empty;
		logic [31:0] age_diff;
		o = '0;
		pick = 1'b0;
		any_empty = 1'b0;
		if (c == aotq_pkg::CMD_ENQ) begin
			o.cls = cls;
			o.tag = tag;
			o.stamp = stamp_ctr;
			if (fill[cls] >= aotq_pkg::QUEUE_DEPTH) begin
				// full: word dropped, counter untouched
				o.status = aotq_pkg::ST_FULL;
				enq_dropped++;
			end else begin
				shelf[cls][wr_ptr[cls]] = '{tag: tag, stamp: stamp_ctr};
				wr_ptr[cls] = ptr_step(wr_ptr[cls]);
				fill[cls]++;
				stamp_ctr = stamp_ctr + 32'd1;
				o.status = aotq_pkg::ST_OK;
				enq_ok++;
			end
		end else begin
			if (c == aotq_pkg::CMD_DEQ_C0 || c == aotq_pkg::CMD_DEQ_C1) begin
				pick = (c == aotq_pkg::CMD_DEQ_C1);
				any_empty = (fill[pick] == 0);
			end else if (fill[0] != 0 && fill[1] != 0) begin
				// older head wins; sign of the modular difference copes with wrap
				age_diff = shelf[0][rd_ptr[0]].stamp - shelf[1][rd_ptr[1]].stamp;
				pick = age_diff[31] ? 1'b0 : 1'b1;
			end else if (fill[0] != 0) begin
				pick = 1'b0;
			end else if (fill[1] != 0) begin
				pick = 1'b1;
			end else begin
				any_empty = 1'b1;
			end
			if (any_empty) begin
				o.status = aotq_pkg::ST_EMPTY;
				deq_empty++;
			end else begin
				o.found = 1'b1;
				o.cls = pick;
				o.tag = shelf[pick][rd_ptr[pick]].tag;
				o.stamp = shelf[pick][rd_ptr[pick]].stamp;
				o.status = aotq_pkg::ST_OK;
				rd_ptr[pick] = ptr_step(rd_ptr[pick]);
				fill[pick]--;
				deq_found++;
				if (c == aotq_pkg::CMD_DEQ_ANY)
					any_picks[pick]++;
			end
		end
		pending_outcomes.push_back(o);
	endtask

	// Presents one command word and returns at the edge that takes it; start is left high.
	task automatic send_word(input aotq_pkg::cmd_t c, input logic cls, input logic [15:0] tag);
		start <= 1'b1;
		cmd <= c;
		item_class <= cls;
		item_tag <= tag;
		do
			@(posedge clk);
		while (busy);
		predict_outcome(c, cls, tag);
		words_sent++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result checker and watchdog. Everything is sampled as it stood before the edge.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (done) begin
				results_seen++;
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display({"unexpected result word: found=%0d class=%0d",
							" tag=%h stamp=%h status=%0d"},
							found, out_class, out_tag, out_stamp, status);
				end else begin
					want = pending_outcomes.pop_front();
					if (found !== want.found || out_class !== want.cls ||
							out_tag !== want.tag || out_stamp !== want.stamp ||
							status !== want.status) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT)
							$display({"mismatch at word %0d: exp found=%0d class=%0d",
								" tag=%h stamp=%h status=%0d, got found=%0d",
								" class=%0d tag=%h stamp=%h status=%0d"},
								results_seen, want.found, want.cls, want.tag,
								want.stamp, want.status, found, out_class,
								out_tag, out_stamp, status);
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no activity for %0d cycles", STALL_LIMIT);
				$display("FAIL age_ordered_two_class_queue");
				$finish;
			end
		end
	end

	// Dequeues of every kind with both queues empty.
	task automatic test_empty_dequeues();
		send_word(aotq_pkg::CMD_DEQ_ANY, 1'b0, 16'h0000);
		send_word(aotq_pkg::CMD_DEQ_C0, 1'b1, 16'hFFFF);
		send_word(aotq_pkg::CMD_DEQ_C1, 1'b0, 16'h0000);
	endtask

	// Extreme tags, age order across classes, class-specific pops, one queue empty.
	task automatic test_age_order();
		send_word(aotq_pkg::CMD_ENQ, 1'b0, 16'h0000);
		send_word(aotq_pkg::CMD_ENQ, 1'b1, 16'hFFFF);
		send_word(aotq_pkg::CMD_ENQ, 1'b0, 16'hFFFF);
		send_word(aotq_pkg::CMD_ENQ, 1'b1, 16'h0000);
		send_word(aotq_pkg::CMD_DEQ_ANY, 1'b1, 16'hA5A5);
		send_word(aotq_pkg::CMD_DEQ_ANY, 1'b0, 16'h5A5A);
		send_word(aotq_pkg::CMD_DEQ_C1, 1'b0, 16'h0000);
		send_word(aotq_pkg::CMD_DEQ_C1, 1'b1, 16'hFFFF);
		send_word(aotq_pkg::CMD_DEQ_ANY, 1'b0, 16'h0000);
		send_word(aotq_pkg::CMD_DEQ_C0, 1'b0, 16'h0000);
		send_word(aotq_pkg::CMD_ENQ, 1'b1, 16'h8001);
		send_word(aotq_pkg::CMD_DEQ_ANY, 1'b0, 16'h0000);
	endtask

	// Hold the sender until the shadow queue of result words is empty.
	task automatic test_drain_pause();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Bursts that can fill a class past full, bursts that drain, and mixed noise.
	task automatic test_random_traffic(input int n_words);
		int             target;
		int             mode;
		int             len;
		bit             gappy;
		logic           burst_cls;
		logic           cls;
		aotq_pkg::cmd_t c;
		target = words_sent + n_words;
		while (words_sent < target) begin
			mode = $urandom_range(0, 9);
			gappy = ($urandom_range(0, 3) != 0);
			burst_cls = 1'($urandom_range(0, 1));
			len = (mode < 4) ? $urandom_range(10, 20) : $urandom_range(6, 24);
			repeat (len) begin
				cls = 1'($urandom_range(0, 1));
				if (mode < 4) begin
					// fill run: mostly one class, at times long enough to overflow it
					c = ($urandom_range(0, 9) == 0) ? aotq_pkg::CMD_DEQ_ANY : aotq_pkg::CMD_ENQ;
					if ($urandom_range(0, 9) != 0)
						cls = burst_cls;
				end else if (mode < 7) begin
					// drain run, weighted to dequeue-any
					case ($urandom_range(0, 5))
						0: c = aotq_pkg::CMD_DEQ_C0;
						1: c = aotq_pkg::CMD_DEQ_C1;
						2: c = aotq_pkg::CMD_ENQ;
						default: c = aotq_pkg::CMD_DEQ_ANY;
					endcase
				end else begin
					c = aotq_pkg::cmd_t'($urandom_range(0, 3));
				end
				send_word(c, cls, 16'($urandom));
				if (gappy)
					idle_for(pick_gap());
			end
		end
	endtask

	initial begin
		for (int q = 0; q < 2; q++) begin
			rd_ptr[q] = '0;
			wr_ptr[q] = '0;
			fill[q] = 0;
		end
		stamp_ctr = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_dequeues();
		test_age_order();
		test_drain_pause();
		test_random_traffic(RANDOM_WORDS / 2);
		test_drain_pause();
		test_random_traffic(RANDOM_WORDS - RANDOM_WORDS / 2);

		// let the last words come back, then idle before the final check
		test_drain_pause();
		repeat (4) @(posedge clk);
		if (pending_outcomes.size() != 0)
			mismatches++;

		$display("sent %0d command words, checked %0d result words, %0d mismatches",
			words_sent, results_seen, mismatches);
		$display({"enqueued %0d, dropped when full %0d, dequeued %0d",
			" (any: c0 %0d c1 %0d), empty %0d"},
			enq_ok, enq_dropped, deq_found, any_picks[0], any_picks[1], deq_empty);
		if (mismatches == 0)
			$display("PASS age_ordered_two_class_queue");
		else
			$display("FAIL age_ordered_two_class_queue");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/aotq_pkg.sv
rtl/age_ordered_two_class_queue.sv
sim/age_ordered_two_class_queue_test.sv
